[sv/soc_pkg.sv]
package soc_pkg;

	localparam int COORD_WIDTH_DEF = 32;
	localparam int FRAC_BITS_DEF   = 16;
	// Depth of the queue between front and back; a power of two.
	localparam int QUEUE_DEPTH     = 4;

endpackage

[sv/soc_front.sv]
module soc_front #(
	parameter int W  = 32,
	parameter int PW = 9 * W + 4
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [2:0][W-1:0]    c_in,
	input  logic [2:0][W-1:0]    p_in,
	input  logic [2:0][W-1:0]    q_in,
	input  logic [W-2:0]         r1_in,
	input  logic [W-2:0]         r2_in,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [PW-1:0]        out_data
);

	logic                en;
	logic                valid_s1, valid_s2;
	logic [W:0]          dif [3];
	logic [W:0]          mag [3];

	logic [2:0][W-1:0]   c_s1;
	logic [W:0]          mag_s1 [3];
	logic [2:0]          neg_s1;
	logic [W-1:0]        rs_s1;

	logic [2:0][W-1:0]   c_s2;
	logic [2:0][W-1:0]   mag_s2;
	logic [2:0]          neg_s2;
	logic [W-1:0]        rs_s2;
	logic [2*W+1:0]      sq_s2 [3];
	logic [2*W-1:0]      r2_s2;

	logic [2*W+1:0]      ssum;
	logic                hit;

	assign en       = !valid_s2 || out_ready;
	assign in_ready = en;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			dif[i] = {p_in[i][W-1], p_in[i]} - {q_in[i][W-1], q_in[i]};
			mag[i] = dif[i][W] ? ((W+1)'(0) - dif[i]) : dif[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			c_s1  <= c_in;
			rs_s1 <= {1'b0, r1_in} + {1'b0, r2_in};
			for (int i = 0; i < 3; i++) begin
				mag_s1[i] <= mag[i];
				neg_s1[i] <= dif[i][W];
			end
			c_s2   <= c_s1;
			rs_s2  <= rs_s1;
			neg_s2 <= neg_s1;
			r2_s2  <= {{W{1'b0}}, rs_s1} * {{W{1'b0}}, rs_s1};
			for (int i = 0; i < 3; i++) begin
				// Only the low W bits matter downstream: an overlap keeps |d_i| below R.
				mag_s2[i] <= mag_s1[i][W-1:0];
				sq_s2[i]  <= {{(W+1){1'b0}}, mag_s1[i]} * {{(W+1){1'b0}}, mag_s1[i]};
			end
		end
	end

	assign ssum      = sq_s2[0] + sq_s2[1] + sq_s2[2];
	assign hit       = ssum < {2'b00, r2_s2};
	assign out_valid = valid_s2;
	assign out_data  = {rs_s2, ssum[2*W-1:0], neg_s2, mag_s2[2], mag_s2[1], mag_s2[0],
		c_s2[2], c_s2[1], c_s2[0], hit};

endmodule

[sv/soc_queue.sv]
module soc_queue #(
	parameter int PW    = 8,
	parameter int DEPTH = 4
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  logic [PW-1:0] in_data,
	output logic          out_valid,
	input  logic          out_ready,
	output logic [PW-1:0] out_data
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [PW-1:0] mem [DEPTH];
	logic [AW-1:0] wr_q, rd_q;
	logic [CW-1:0] cnt_q;
	logic          push, pop;

	assign in_ready  = cnt_q != CW'(DEPTH);
	assign out_valid = cnt_q != '0;
	assign push      = in_valid && in_ready;
	assign pop       = out_valid && out_ready;
	assign out_data  = mem[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + AW'(1);
			if (pop) rd_q <= rd_q + AW'(1);
			cnt_q <= cnt_q + CW'(push) - CW'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem[wr_q] <= in_data;
	end

endmodule

[sv/soc_back.sv]
module soc_back #(
	parameter int W  = 32,
	parameter int F  = 16,
	parameter int PW = 9 * W + 4
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [PW-1:0]        in_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic                 out_hit,
	output logic [2:0][W-1:0]    out_center
);

	localparam int QW = F + 1;
	// Square root steps, one prep stage, divider steps, multiply, output.
	localparam int NS = W + QW + 3;

	typedef struct packed {
		logic                  hit;
		logic [2:0][W-1:0]     c;
		logic [2:0][W-1:0]     mag;
		logic [2:0]            neg;
		logic [2*W-1:0]        s;
		logic [W-1:0]          rs;
		logic [W-1:0]          root;
		logic [W+1:0]          srem;
		logic [W-2:0]          half;
		logic                  lz;
		logic [2:0][W+F-1:0]   rem;
		logic [2:0][F:0]       q;
		logic [2:0][F+W-1:0]   prod;
		logic [2:0][W-1:0]     res;
	} bk_t;

	logic en;
	bk_t  head;
	bk_t  stg_in  [1:NS];
	bk_t  nx      [1:NS];
	bk_t  data_s  [1:NS];
	logic vin     [1:NS];
	logic valid_s [1:NS];

	assign en       = !valid_s[NS] || out_ready;
	assign in_ready = en;

	always_comb begin
		head      = '0;
		head.hit  = in_data[0];
		for (int i = 0; i < 3; i++) begin
			head.c[i]   = in_data[1 + i*W +: W];
			head.mag[i] = in_data[1 + 3*W + i*W +: W];
		end
		head.neg = in_data[1 + 6*W +: 3];
		head.s   = in_data[4 + 6*W +: 2*W];
		head.rs  = in_data[4 + 8*W +: W];
	end

	for (genvar g = 1; g <= NS; g++) begin : g_stage
		if (g == 1) begin : g_first
			assign stg_in[g] = head;
			assign vin[g]    = in_valid;
		end else begin : g_next
			assign stg_in[g] = data_s[g-1];
			assign vin[g]    = valid_s[g-1];
		end

		if (g <= W) begin : g_sqrt
			localparam int SI = g - 1;
			logic [W+1:0] rx, tr;
			always_comb begin
				nx[g] = stg_in[g];
				rx = {stg_in[g].srem[W-1:0], stg_in[g].s[2*W-1-2*SI -: 2]};
				tr = {stg_in[g].root, 2'b01};
				if (rx >= tr) begin
					nx[g].srem = rx - tr;
					nx[g].root = {stg_in[g].root[W-2:0], 1'b1};
				end else begin
					nx[g].srem = rx;
					nx[g].root = {stg_in[g].root[W-2:0], 1'b0};
				end
			end
		end else if (g == W + 1) begin : g_prep
			logic [W-1:0] gap;
			always_comb begin
				nx[g] = stg_in[g];
				gap = stg_in[g].rs - stg_in[g].root;
				nx[g].half = gap[W-1:1];
				nx[g].lz   = stg_in[g].root == '0;
				for (int i = 0; i < 3; i++) begin
					nx[g].rem[i] = {stg_in[g].mag[i], {F{1'b0}}};
					nx[g].q[i]   = '0;
				end
			end
		end else if (g <= W + 1 + QW) begin : g_div
			localparam int K = F - (g - W - 2);
			logic [W+F-1:0] dsh;
			always_comb begin
				nx[g] = stg_in[g];
				dsh = {{F{1'b0}}, stg_in[g].root} << K;
				for (int i = 0; i < 3; i++) begin
					if (stg_in[g].rem[i] >= dsh) begin
						nx[g].rem[i]  = stg_in[g].rem[i] - dsh;
						nx[g].q[i][K] = 1'b1;
					end
				end
			end
		end else if (g == W + 2 + QW) begin : g_mul
			always_comb begin
				nx[g] = stg_in[g];
				for (int i = 0; i < 3; i++) begin
					nx[g].prod[i] = {{(W-1){1'b0}}, stg_in[g].q[i]}
						* {{(F+1){1'b0}}, stg_in[g].half};
				end
			end
		end else begin : g_out
			logic [W-2:0] mv  [3];
			logic [W:0]   sum [3];
			always_comb begin
				nx[g] = stg_in[g];
				for (int i = 0; i < 3; i++) begin
					mv[i] = stg_in[g].prod[i][F +: W-1];
					// No overlap, or coincident centers: the center stays put.
					if (!stg_in[g].hit || stg_in[g].lz) mv[i] = '0;
					if (stg_in[g].neg[i]) begin
						sum[i] = {stg_in[g].c[i][W-1], stg_in[g].c[i]} - {2'b00, mv[i]};
					end else begin
						sum[i] = {stg_in[g].c[i][W-1], stg_in[g].c[i]} + {2'b00, mv[i]};
					end
					if (sum[i][W] != sum[i][W-1]) begin
						nx[g].res[i] = sum[i][W] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
					end else begin
						nx[g].res[i] = sum[i][W-1:0];
					end
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[g] <= 1'b0;
			end else if (en) begin
				valid_s[g] <= vin[g];
			end
		end

		always_ff @(posedge clk) begin
			if (en) data_s[g] <= nx[g];
		end
	end

	assign out_valid  = valid_s[NS];
	assign out_hit    = data_s[NS].hit;
	assign out_center = data_s[NS].res;

endmodule

[sv/sphere_overlap_correction.sv]
// Channel   Dir  Handshake                   Payload
// s_axis    in   s_axis_tvalid/tready        tdata: center xyz, first xyz, first radius,
//                                            second xyz, second radius
// m_axis    out  m_axis_tvalid/tready        tdata: new center xyz; tuser: collided
//
// One item per cycle sustained while m_axis is ready. The front registers each item in
// stages s1 and s2, the queue sits between front and back, and the length of the back
// pipeline is set by the bit-per-stage square root and the bit-per-stage normalizing
// divider. Reset clears all valid flags and the queue. A stall on m_axis freezes the back
// pipeline; the front keeps taking items until the queue fills.
module sphere_overlap_correction #(
	parameter int COORD_WIDTH = soc_pkg::COORD_WIDTH_DEF,
	parameter int FRAC_BITS   = soc_pkg::FRAC_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_axis_tvalid,
	output logic s_axis_tready,
	// center_x, center_y, center_z, first_x, first_y, first_z, first_radius,
	// second_x, second_y, second_z, second_radius
	input  logic [((11*COORD_WIDTH-2+7)/8)*8-1:0] s_axis_tdata,
	output logic m_axis_tvalid,
	input  logic m_axis_tready,
	// new_center_x, new_center_y, new_center_z
	output logic [((3*COORD_WIDTH+7)/8)*8-1:0] m_axis_tdata,
	// collided
	output logic [0:0] m_axis_tuser
);
	import soc_pkg::*;

	localparam int W   = COORD_WIDTH;
	localparam int PW  = 9 * W + 4;
	localparam int OBW = ((3*W+7)/8)*8;

	logic [2:0][W-1:0] c_in, p_in, q_in, ctr;
	logic [W-2:0]      r1_in, r2_in;
	logic              fr_valid, q_ready, q_valid, bk_ready, hit;
	logic [PW-1:0]     fr_data, q_data;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			c_in[i] = s_axis_tdata[i*W +: W];
			p_in[i] = s_axis_tdata[3*W + i*W +: W];
			q_in[i] = s_axis_tdata[7*W - 1 + i*W +: W];
		end
		r1_in = s_axis_tdata[6*W +: W-1];
		r2_in = s_axis_tdata[10*W - 1 +: W-1];
	end

	soc_front #(.W(W), .PW(PW)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.c_in      (c_in),
		.p_in      (p_in),
		.q_in      (q_in),
		.r1_in     (r1_in),
		.r2_in     (r2_in),
		.out_valid (fr_valid),
		.out_ready (q_ready),
		.out_data  (fr_data)
	);

	soc_queue #(.PW(PW), .DEPTH(QUEUE_DEPTH)) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (fr_valid),
		.in_ready  (q_ready),
		.in_data   (fr_data),
		.out_valid (q_valid),
		.out_ready (bk_ready),
		.out_data  (q_data)
	);

	soc_back #(.W(W), .F(FRAC_BITS), .PW(PW)) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (q_valid),
		.in_ready   (bk_ready),
		.in_data    (q_data),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.out_hit    (hit),
		.out_center (ctr)
	);

	assign m_axis_tdata = OBW'({ctr[2], ctr[1], ctr[0]});
	assign m_axis_tuser = hit;

`ifndef ASSERT_OFF
	// An item left by the front for a full queue is still there in the next cycle.
	a_front_holds: assert property (@(posedge clk) disable iff (!arst_n)
		fr_valid && !q_ready |=> fr_valid)
		else $error("front item dropped while queue full");

	// The queue cannot be full and empty at once.
	a_queue_sane: assert property (@(posedge clk) disable iff (!arst_n)
		q_ready || q_valid)
		else $error("queue full and empty at once");

	// The front only stalls the input while the queue is full.
	a_front_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> fr_valid && !q_ready)
		else $error("input stalled without a full queue");
`endif

endmodule

[dv/overlap_checker.sv]
`timescale 1ns / 100ps

module overlap_checker (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	input  logic         s_axis_tready,
	input  logic [351:0] s_axis_tdata,
	input  logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	input  logic [95:0]  m_axis_tdata,
	input  logic [0:0]   m_axis_tuser,
	output int           errors,
	output int           pending,
	output int           hits
);

	// Bit 96 is the collision flag, bits 95:0 the corrected center.
	logic [96:0] centers_due[$];

	function automatic logic signed [127:0] clamp_coord(logic signed [127:0] v);
		logic signed [127:0] hi;
		logic signed [127:0] lo;
		hi = 128'sh7fffffff;
		lo = -hi - 1;
		if (v > hi) return hi;
		if (v < lo) return lo;
		return v;
	endfunction

	function automatic logic [96:0] correct_center(logic [351:0] d);
		logic signed [31:0]  cc, pp, qq;
		logic signed [127:0] c[3];
		logic signed [127:0] dd[3];
		logic signed [127:0] v;
		logic [127:0]        m, s, rs, r2, len, t, half, nrm, mv;
		logic [96:0]         res;
		bit                  hit;
		s = '0;
		for (int i = 0; i < 3; i++) begin
			cc = d[32*i +: 32];
			pp = d[96 + 32*i +: 32];
			qq = d[223 + 32*i +: 32];
			c[i] = 128'(cc);
			dd[i] = 128'(pp);
			dd[i] = dd[i] - 128'(qq);
			m = (dd[i] < 0) ? -dd[i] : dd[i];
			s = s + m * m;
		end
		rs = {97'd0, d[222:192]} + {97'd0, d[349:319]};
		r2 = rs * rs;
		hit = s < r2;
		res = '0;
		res[96] = hit;
		if (!hit) begin
			for (int i = 0; i < 3; i++) res[32*i +: 32] = c[i][31:0];
			return res;
		end
		len = '0;
		for (int b = 40; b >= 0; b--) begin
			t = len | (128'd1 << b);
			if (t * t <= s) len = t;
		end
		half = (rs - len) >> 1;
		for (int i = 0; i < 3; i++) begin
			v = c[i];
			// Coincident centers leave the normal at zero.
			if (len != 0) begin
				m = (dd[i] < 0) ? -dd[i] : dd[i];
				nrm = (m << 16) / len;
				mv = (nrm * half) >> 16;
				if (dd[i] < 0) v = v - $signed(mv);
				else v = v + $signed(mv);
			end
			v = clamp_coord(v);
			res[32*i +: 32] = v[31:0];
		end
		return res;
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		$display("%0t: %s mismatch: got %h, expected %h", $realtime, what, got, want);
		errors++;
	endtask

	initial begin
		errors = 0;
		hits = 0;
	end

	assign pending = centers_due.size();

	always @(posedge clk) begin
		logic [96:0] want;
		if (arst_n && s_axis_tvalid && s_axis_tready) begin
			want = correct_center(s_axis_tdata);
			if (want[96]) hits++;
			centers_due.push_back(want);
		end
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (centers_due.size() == 0) begin
				report_mismatch("unexpected item", m_axis_tdata[31:0], 32'd0);
			end else begin
				want = centers_due.pop_front();
				if (m_axis_tuser[0] !== want[96])
					report_mismatch("collided", {31'd0, m_axis_tuser[0]}, {31'd0, want[96]});
				if (m_axis_tdata[31:0] !== want[31:0])
					report_mismatch("new_center_x", m_axis_tdata[31:0], want[31:0]);
				if (m_axis_tdata[63:32] !== want[63:32])
					report_mismatch("new_center_y", m_axis_tdata[63:32], want[63:32]);
				if (m_axis_tdata[95:64] !== want[95:64])
					report_mismatch("new_center_z", m_axis_tdata[95:64], want[95:64]);
			end
		end
	end

endmodule

[dv/sphere_overlap_correction_tb.sv]
`timescale 1ns / 100ps

module sphere_overlap_correction_tb;

	localparam int CYCLE_LIMIT = 200000;
	localparam int RANDOM_ITEMS = 600;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_axis_tvalid = 1'b0;
	logic         s_axis_tready;
	logic [351:0] s_axis_tdata = '0;
	logic         m_axis_tvalid;
	logic         m_axis_tready = 1'b0;
	logic [95:0]  m_axis_tdata;
	logic [0:0]   m_axis_tuser;

	int  errors, pending, hits;
	int  sent = 0;
	int  cycles = 0;
	bit  quiet = 0;
	bit  held = 0;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	sphere_overlap_correction dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser)
	);

	overlap_checker u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser),
		.errors(errors),
		.pending(pending),
		.hits(hits)
	);

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles", cycles);
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	task automatic send_pair(logic [31:0] cx, logic [31:0] cy, logic [31:0] cz,
			logic [31:0] px, logic [31:0] py, logic [31:0] pz, logic [30:0] r1,
			logic [31:0] qx, logic [31:0] qy, logic [31:0] qz, logic [30:0] r2);
		if (!quiet && $urandom_range(0, 3) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 9)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {2'b00, r2, qz, qy, qx, r1, pz, py, px, cz, cy, cx};
		do @(posedge clk); while (!s_axis_tready);
		sent++;
	endtask

	task automatic send_random_pair();
		logic [31:0] c[3], p[3], q[3];
		logic [30:0] r1, r2;
		int          mode;
		mode = $urandom_range(0, 19);
		for (int i = 0; i < 3; i++) begin
			c[i] = $urandom;
			p[i] = $urandom;
			// Near the edges of the range the move is likely to saturate.
			if ($urandom_range(0, 7) == 0) c[i] = {c[i][31], {11{~c[i][31]}}, c[i][19:0]};
		end
		if (mode < 5) begin
			for (int i = 0; i < 3; i++) q[i] = $urandom;
			r1 = 31'($urandom);
			r2 = 31'($urandom);
		end else begin
			for (int i = 0; i < 3; i++)
				q[i] = p[i] + $signed(32'($urandom_range(0, 1 << 21))) - (1 << 20);
			r1 = 31'($urandom_range(0, 1 << 21));
			r2 = 31'($urandom_range(0, 1 << 21));
			// Mostly overlapping pairs, a few well apart.
			if (mode < 8) begin
				r1 = r1 >> 4;
				r2 = r2 >> 4;
			end
			if (mode == 19) q = p;
		end
		send_pair(c[0], c[1], c[2], p[0], p[1], p[2], r1, q[0], q[1], q[2], r2);
	endtask

	initial begin
		forever begin
			@(posedge clk);
			if (arst_n) begin
				if (!held && sent >= 150) begin
					held = 1;
					m_axis_tready <= 1'b0;
					repeat (400) @(posedge clk);
				end else if (!quiet && $urandom_range(0, 3) == 0) begin
					m_axis_tready <= 1'b0;
					repeat ($urandom_range(0, 8)) @(posedge clk);
				end else begin
					m_axis_tready <= 1'b1;
					repeat ($urandom_range(0, 11)) @(posedge clk);
				end
			end
		end
	end

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// All zero: no radius, no overlap.
		send_pair(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
		// Coincident centers with a radius: collision but no move.
		send_pair(32'h0001_0000, 32'hffff_0000, 5, 7, 7, 7, 31'h0001_0000, 7, 7, 7, 0);
		// Touching along x: no collision.
		send_pair(1, 2, 3, 32'h0002_0000, 0, 0, 31'h0001_0000, 0, 0, 0, 31'h0001_0000);
		// Just inside touching.
		send_pair(1, 2, 3, 32'h0001_ffff, 0, 0, 31'h0001_0000, 0, 0, 0, 31'h0001_0000);
		// Deep overlap along each axis and both signs.
		send_pair(0, 0, 0, 32'h0000_8000, 0, 0, 31'h0004_0000, 0, 0, 0, 31'h0004_0000);
		send_pair(0, 0, 0, 0, 32'hffff_8000, 0, 31'h0004_0000, 0, 0, 0, 31'h0004_0000);
		send_pair(0, 0, 0, 0, 0, 32'h0000_0001, 31'h0004_0000, 0, 0, 0, 31'h0004_0000);
		send_pair(0, 0, 0, 32'h0001_0000, 32'h0001_0000, 32'hffff_0000,
			31'h0002_0000, 0, 0, 0, 31'h0002_0000);
		// Saturation at the top and bottom of the range.
		send_pair(32'h7fff_ffff, 32'h7fff_fff0, 32'h8000_0000, 32'h0000_0100, 32'h0000_0100,
			32'hffff_ff00, 31'h7fff_ffff, 0, 0, 0, 31'h7fff_ffff);
		send_pair(32'h8000_0000, 32'h8000_0001, 32'h7fff_ffff, 32'hffff_ff00, 32'hffff_ff00,
			32'h0000_0100, 31'h7fff_ffff, 0, 0, 0, 31'h7fff_ffff);
		// Largest distances and largest radii.
		send_pair(32'h7fff_ffff, 32'h8000_0000, 32'h1234_5678, 32'h7fff_ffff, 32'h7fff_ffff,
			32'h7fff_ffff, 31'h7fff_ffff, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
			31'h7fff_ffff);
		send_pair(32'hffff_ffff, 0, 32'hffff_ffff, 32'h8000_0000, 32'h7fff_ffff,
			32'h8000_0000, 31'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff,
			31'h7fff_ffff);
		send_pair(32'haaaa_aaaa, 32'h5555_5555, 32'hffff_ffff, 32'h4000_0000, 0, 0,
			31'h7fff_ffff, 32'hc000_0000, 0, 0, 31'h0000_0001);
		// Smallest nonzero distance.
		send_pair(0, 0, 0, 1, 0, 0, 31'h0000_0001, 0, 0, 0, 31'h0000_0001);
		send_pair(0, 0, 0, 1, 1, 1, 31'h0000_0010, 0, 0, 0, 0);

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n == RANDOM_ITEMS - 80) quiet = 1;
			send_random_pair();
		end
		quiet = 1;
		s_axis_tvalid <= 1'b0;

		while (pending != 0) @(posedge clk);
		repeat (120) @(posedge clk);

		$display("Sent %0d sphere pairs, %0d of them overlapping, with gaps and a long", sent, hits);
		$display("output hold-off that backed up the pipeline.");
		if (errors == 0 && pending == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule

[files.f]
sv/soc_pkg.sv
sv/soc_front.sv
sv/soc_queue.sv
sv/soc_back.sv
sv/sphere_overlap_correction.sv
dv/overlap_checker.sv
dv/sphere_overlap_correction_tb.sv
